@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sard_pkg.sv @@
`default_nettype none

package sard_pkg;

  // Table geometry
  localparam int SLOTS   = 1024;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Field widths
  localparam int SLOT_W  = 10;
  localparam int TIME_W  = 32;
  localparam int MS_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  // Mark must hold both a slot count and any first_slot value
  localparam int MARK_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_FIRST_SLOT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_QUARANTINE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STARTUP    = 2'd2;

  // Register reset values
  localparam logic [SLOT_W-1:0] FIRST_SLOT_RST = 10'd33;
  localparam logic [MS_W-1:0]   QUARANTINE_RST = 16'd500;
  localparam logic [MS_W-1:0]   STARTUP_RST    = 16'd2000;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Last slot, as the result field shows it
  localparam logic [SLOT_W-1:0] LAST_SLOT_OUT = SLOT_W'(SLOTS - 1);

endpackage

`default_nettype wire

@@ rtl/slot_allocator_with_reuse_delay.sv @@
`default_nettype none

// Slot allocator with reuse delay. After reset the block clears its table of
// free flags, one slot per cycle, and takes no request before the clear is
// done. Configuration writes are taken at any time except during an
// allocation scan, and a write that is offered holds off new requests for
// that cycle. A free request puts its result in the working stage, which
// moves on into the output register once that register has room. An
// allocation walks the table through a memory with registered reads, one
// slot per cycle from first_slot up to the high-water mark; the first
// reusable slot that it meets ends the walk. One request is in progress at a
// time; the next one is taken as soon as the result leaves the working stage,
// even while the previous result still waits in the output register.
module slot_allocator_with_reuse_delay import sard_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  input  wire logic [TIME_W-1:0] in_now_ms,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [SLOT_W-1:0] out_slot,
  output logic                   out_stolen,
  output logic                   out_bad_index,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [MARK_W-1:0] SLOTS_M = MARK_W'(SLOTS);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(SLOTS - 1);

  // Memories: free flags (cleared after reset) and free timestamps
  logic              free_mem [SLOTS];
  logic [TIME_W-1:0] time_mem [SLOTS];

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0] first_slot_r;
  logic [MS_W-1:0]   quar_r;
  logic [MS_W-1:0]   startup_r;
  logic [MARK_W-1:0] top_mark_r, top_mark_nxt;

  logic [MARK_W-1:0] mark_r, mark_nxt;
  logic [MARK_W-1:0] lim_r, lim_nxt;
  logic [MARK_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0] chk_addr_r, chk_addr_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;

  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_stolen_r, res_stolen_nxt;
  logic              res_bad_r, res_bad_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_stolen_r, out_stolen_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              free_q;
  logic [TIME_W-1:0] time_q;

  logic              fm_we;
  logic [ADDR_W-1:0] fm_waddr;
  logic              fm_wdata;
  logic              tm_we;
  logic [ADDR_W-1:0] tm_waddr;
  logic [TIME_W-1:0] tm_wdata;

  logic              in_acc;
  logic              out_free;
  logic [MARK_W-1:0] mark_cur;
  logic [MARK_W-1:0] first_m;
  logic [MARK_W-1:0] idx_m;
  logic              idx_bad;
  logic              issue;
  logic [TIME_W-1:0] elapsed;
  logic              reusable;

  // Hold requests off while busy or while a register write is offered
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r != ST_SCAN);
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_stolen    = out_stolen_r;
  assign out_bad_index = out_bad_r;

  // Effective mark: reserved slots push it up to first_slot
  assign first_m  = MARK_W'(first_slot_r);
  assign mark_cur = (top_mark_r < first_m) ? first_m : top_mark_r;
  assign idx_m    = MARK_W'(in_slot_index);
  assign idx_bad  = (idx_m >= mark_cur) || (idx_m >= SLOTS_M);

  // Scan test on the entry whose data just came back
  assign issue    = (rd_addr_r < lim_r);
  assign elapsed  = now_r - time_q;
  assign reusable = free_q && ((time_q < TIME_W'(startup_r)) ||
                               (elapsed > TIME_W'(quar_r)));

  // Control and datapath next values
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    top_mark_nxt   = top_mark_r;
    mark_nxt       = mark_r;
    lim_nxt        = lim_r;
    rd_addr_nxt    = rd_addr_r;
    chk_addr_nxt   = chk_addr_r;
    chk_vld_nxt    = 1'b0;
    now_nxt        = now_r;
    res_slot_nxt   = res_slot_r;
    res_stolen_nxt = res_stolen_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_stolen_nxt = out_stolen_r;
    out_bad_nxt    = out_bad_r;
    fm_we          = 1'b0;
    fm_waddr       = clr_addr_r;
    fm_wdata       = 1'b0;
    tm_we          = 1'b0;
    tm_waddr       = ADDR_W'(in_slot_index);
    tm_wdata       = in_now_ms;

    case (state_r)
      ST_CLR: begin
        // sweep the free flags to zero
        fm_we        = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt = in_now_ms;
          if (in_mode == MODE_FREE) begin
            // free: mark and stamp the slot unless out of range
            res_slot_nxt   = in_slot_index;
            res_stolen_nxt = 1'b0;
            res_bad_nxt    = idx_bad;
            fm_we          = !idx_bad;
            fm_waddr       = ADDR_W'(in_slot_index);
            fm_wdata       = 1'b1;
            tm_we          = !idx_bad;
            state_nxt      = ST_FIN;
          end else begin
            // allocate: start the scan at first_slot
            mark_nxt    = mark_cur;
            lim_nxt     = (mark_cur < SLOTS_M) ? mark_cur : SLOTS_M;
            rd_addr_nxt = first_m;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // advance the read pointer while inside the range
        if (issue) begin
          rd_addr_nxt  = rd_addr_r + 1'b1;
          chk_addr_nxt = rd_addr_r[ADDR_W-1:0];
          chk_vld_nxt  = 1'b1;
        end
        if (chk_vld_r && reusable) begin
          // take the lowest reusable slot
          fm_we          = 1'b1;
          fm_waddr       = chk_addr_r;
          fm_wdata       = 1'b0;
          res_slot_nxt   = SLOT_W'(chk_addr_r);
          res_stolen_nxt = 1'b0;
          res_bad_nxt    = 1'b0;
          chk_vld_nxt    = 1'b0;
          state_nxt      = ST_FIN;
        end else if (!chk_vld_r && !issue) begin
          res_bad_nxt = 1'b0;
          state_nxt   = ST_FIN;
          if (mark_r >= SLOTS_M) begin
            // table full: take over the last slot
            fm_we          = 1'b1;
            fm_waddr       = LAST_A;
            fm_wdata       = 1'b0;
            tm_we          = 1'b1;
            tm_waddr       = LAST_A;
            tm_wdata       = now_r;
            res_slot_nxt   = LAST_SLOT_OUT;
            res_stolen_nxt = 1'b1;
          end else begin
            // grow: take the slot at the mark
            fm_we          = 1'b1;
            fm_waddr       = mark_r[ADDR_W-1:0];
            fm_wdata       = 1'b0;
            top_mark_nxt   = mark_r + 1'b1;
            res_slot_nxt   = SLOT_W'(mark_r);
            res_stolen_nxt = 1'b0;
          end
        end
      end
      ST_FIN: begin
        // hand the result to the output register once it has room
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_stolen_nxt = res_stolen_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      top_mark_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      top_mark_r  <= top_mark_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_slot_r <= FIRST_SLOT_RST;
      quar_r       <= QUARANTINE_RST;
      startup_r    <= STARTUP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_SLOT: first_slot_r <= cfg_wdata[SLOT_W-1:0];
        CFG_QUARANTINE: quar_r       <= cfg_wdata[MS_W-1:0];
        CFG_STARTUP:    startup_r    <= cfg_wdata[MS_W-1:0];
        default:        ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mark_r       <= mark_nxt;
    lim_r        <= lim_nxt;
    rd_addr_r    <= rd_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    now_r        <= now_nxt;
    res_slot_r   <= res_slot_nxt;
    res_stolen_r <= res_stolen_nxt;
    res_bad_r    <= res_bad_nxt;
    out_slot_r   <= out_slot_nxt;
    out_stolen_r <= out_stolen_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // Free flag memory; writes and scan reads never meet on one entry
  always_ff @(posedge clk) begin
    if (fm_we) begin
      free_mem[fm_waddr] <= fm_wdata;
    end
    free_q <= free_mem[rd_addr_r[ADDR_W-1:0]];
  end

  // Timestamp memory
  always_ff @(posedge clk) begin
    if (tm_we) begin
      time_mem[tm_waddr] <= tm_wdata;
    end
    time_q <= time_mem[rd_addr_r[ADDR_W-1:0]];
  end

endmodule

`default_nettype wire

@@ rtl/sard_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module sard_checker import sard_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [SLOT_W-1:0] out_slot,
  input wire logic              out_stolen,
  input wire logic              out_bad_index
);

  // A waiting result keeps its slot while stalled
  `ASSERT_ON(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_slot), "result changed under stall")

  // A request in progress blocks the next one
  `ASSERT_ON(a_busy_after_req, in_valid && !in_stall |=> in_stall, "request taken while busy")

  // Steal and range error never come together
  `ASSERT_ON(a_flags_excl, out_valid |-> !(out_stolen && out_bad_index), "stolen with bad index")

  // A steal always hands out the last slot
  `ASSERT_ON(a_steal_last, out_valid && out_stolen |-> out_slot == LAST_SLOT_OUT, "steal not on last slot")

  // Reset empties the output
  `ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result after reset")

endmodule

bind slot_allocator_with_reuse_delay sard_checker u_sard_checker (.*);

`default_nettype wire
